[hdl/s5hp_pkg.sv]
package s5hp_pkg;

  // Session phases of the handshake parser.
  typedef enum logic [3:0] {
    PH_G_VER   = 4'd0,
    PH_G_NMETH = 4'd1,
    PH_G_METH  = 4'd2,
    PH_R_VER   = 4'd3,
    PH_R_CMD   = 4'd4,
    PH_R_RSV   = 4'd5,
    PH_R_ATYP  = 4'd6,
    PH_DLEN    = 4'd7,
    PH_ADDR    = 4'd8,
    PH_PORT_H  = 4'd9,
    PH_PORT_L  = 4'd10,
    PH_EST     = 4'd11,
    PH_CLOSED  = 4'd12
  } phase_t;

  // Result kinds, carried on out_tuser.
  typedef enum logic [2:0] {
    KIND_REPLY   = 3'd0,
    KIND_ADDR    = 3'd1,
    KIND_CONNECT = 3'd2,
    KIND_PAYLOAD = 3'd3,
    KIND_ERROR   = 3'd4
  } kind_t;

  // Error codes on error results.
  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_GREETING = 3'd1,
    ERR_HEADER   = 3'd2,
    ERR_ATYP     = 3'd3,
    ERR_DLEN     = 3'd4
  } err_t;

  // Address type reported on a connect result.
  typedef enum logic [1:0] {
    AK_IPV4   = 2'd0,
    AK_DOMAIN = 2'd1,
    AK_IPV6   = 2'd2
  } addr_kind_t;

  // Protocol byte values.
  localparam logic [7:0] SOCKS_VER   = 8'h05;
  localparam logic [7:0] CMD_CONNECT = 8'h01;
  localparam logic [7:0] RSV_BYTE    = 8'h00;
  localparam logic [7:0] METHOD_NONE = 8'h00;
  localparam logic [7:0] ATYP_IPV4   = 8'h01;
  localparam logic [7:0] ATYP_DOMAIN = 8'h03;
  localparam logic [7:0] ATYP_IPV6   = 8'h04;
  localparam logic [7:0] IPV4_LEN    = 8'd4;
  localparam logic [7:0] IPV6_LEN    = 8'd16;

  // Reset value of the domain length limit.
  localparam logic [7:0] MAX_DOMAIN_RESET = 8'd253;

  // Default depth of the result queue; a power of two, at least 2.
  localparam int OUT_DEPTH_DEF = 4;

  // One result item.
  typedef struct packed {
    kind_t      kind;
    logic [7:0] data;
    addr_kind_t akind;
    logic [15:0] port;
    logic [7:0] alen;
    err_t       err;
    logic       last;
  } result_t;

  // Results produced by one input transfer: zero, one or two.
  typedef struct packed {
    logic [1:0] cnt;
    result_t    r0;
    result_t    r1;
  } parse_out_t;

  function automatic result_t make_res(kind_t kind, logic [7:0] data, addr_kind_t akind,
                                       logic [15:0] port, logic [7:0] alen, err_t err,
                                       logic last);
    result_t r;
    r.kind  = kind;
    r.data  = data;
    r.akind = akind;
    r.port  = port;
    r.alen  = alen;
    r.err   = err;
    r.last  = last;
    return r;
  endfunction

endpackage

[hdl/socks5_handshake_parser_unit.sv]
// SOCKS5 server handshake parser. One client byte enters per transfer on the
// in_ channel (tuser = restart flag, tlast = end of a received chunk) and the
// unit sustains one byte per clock while the result queue has room. Each byte
// is held in an input register, parsed by the session state machine, and its
// results (none, one, or the two-byte 05 00 method reply) go into a small
// result queue; input is taken while that queue has room for a two-result
// burst, so a stall on out_tready backs up into in_tready once the queue lacks
// room for such a burst. cfg_we writes the domain length limit (reset 253);
// write it only while no bytes are in flight.
module socks5_handshake_parser_unit #(
  parameter int OUT_DEPTH = s5hp_pkg::OUT_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: domain length limit.
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] in_byte
  input  logic        in_tuser,   // [0] mode (restart)
  input  logic        in_tlast,   // chunk_last
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] out_byte, [9:8] addr_kind, [25:10] dest_port,
                                  // [33:26] addr_bytes, [36:34] error_code, [39:37] zero
  output logic [2:0]  out_tuser,  // [2:0] out_kind
  output logic        out_tlast   // out_last
);
  import s5hp_pkg::*;

  logic       in_v_r;
  logic       in_mode_r;
  logic [7:0] in_byte_r;
  logic       in_last_r;
  logic       room;
  logic       fire;
  logic       in_acc;
  parse_out_t pres;
  logic [1:0] push_cnt;
  result_t    head;

  assign fire      = in_v_r && room;
  assign in_tready = !in_v_r || room;
  assign in_acc    = in_tvalid && in_tready;
  assign push_cnt  = fire ? pres.cnt : 2'd0;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_mode_r <= in_tuser;
      in_byte_r <= in_tdata;
      in_last_r <= in_tlast;
    end
  end

  s5hp_parser u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .item_fire (fire),
    .item_mode (in_mode_r),
    .item_byte (in_byte_r),
    .item_last (in_last_r),
    .res       (pres)
  );

  s5hp_out_queue #(
    .DEPTH (OUT_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (pres.r0),
    .push1      (pres.r1),
    .room       (room),
    .head_valid (out_tvalid),
    .head_ready (out_tready),
    .head       (head)
  );

  // Pack the head result onto the output stream.
  assign out_tdata = {3'b000, head.err, head.alen, head.port, head.akind, head.data};
  assign out_tuser = head.kind;
  assign out_tlast = head.last;

endmodule

[hdl/s5hp_parser.sv]
module s5hp_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [7:0]           cfg_wdata,
  input  logic                 item_fire,
  input  logic                 item_mode,
  input  logic [7:0]           item_byte,
  input  logic                 item_last,
  output s5hp_pkg::parse_out_t res
);
  import s5hp_pkg::*;

  phase_t     phase_r, phase_nxt;
  logic [7:0] bytes_left_r, bytes_left_nxt;
  addr_kind_t akind_r, akind_nxt;
  logic [7:0] port_high_r, port_high_nxt;
  logic [7:0] alen_r, alen_nxt;
  logic [7:0] max_dlen_r;
  logic [7:0] bl_dec;

  // Domain length limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_dlen_r <= MAX_DOMAIN_RESET;
    end else if (cfg_we) begin
      max_dlen_r <= cfg_wdata;
    end
  end

  // Session state, updated on every transfer taken from the input stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= PH_G_VER;
      bytes_left_r <= 8'd0;
      akind_r      <= AK_IPV4;
      port_high_r  <= 8'd0;
      alen_r       <= 8'd0;
    end else if (item_fire) begin
      phase_r      <= phase_nxt;
      bytes_left_r <= bytes_left_nxt;
      akind_r      <= akind_nxt;
      port_high_r  <= port_high_nxt;
      alen_r       <= alen_nxt;
    end
  end

  assign bl_dec = bytes_left_r - 8'd1;

  // Next state and results for the current byte.
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    akind_nxt      = akind_r;
    port_high_nxt  = port_high_r;
    alen_nxt       = alen_r;
    res.cnt        = 2'd0;
    res.r0         = make_res(KIND_REPLY, SOCKS_VER, AK_IPV4, 16'd0, 8'd0, ERR_NONE, 1'b0);
    res.r1         = make_res(KIND_REPLY, METHOD_NONE, AK_IPV4, 16'd0, 8'd0, ERR_NONE, 1'b1);

    if (item_mode) begin
      // Restart clears the session but keeps the limit register.
      phase_nxt      = PH_G_VER;
      bytes_left_nxt = 8'd0;
      akind_nxt      = AK_IPV4;
      port_high_nxt  = 8'd0;
      alen_nxt       = 8'd0;
    end else begin
      case (phase_r)
        PH_G_VER: begin
          if (item_byte != SOCKS_VER) begin
            phase_nxt = PH_CLOSED;
            res.cnt   = 2'd1;
            res.r0    = make_res(KIND_ERROR, item_byte, AK_IPV4, 16'd0, 8'd0,
                                 ERR_GREETING, 1'b1);
          end else begin
            phase_nxt = PH_G_NMETH;
          end
        end
        PH_G_NMETH: begin
          // An empty method list answers at once.
          if (item_byte == 8'd0) begin
            phase_nxt = PH_R_VER;
            res.cnt   = 2'd2;
          end else begin
            bytes_left_nxt = item_byte;
            phase_nxt      = PH_G_METH;
          end
        end
        PH_G_METH: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_nxt = PH_R_VER;
            res.cnt   = 2'd2;
          end
        end
        PH_R_VER, PH_R_CMD, PH_R_RSV: begin
          logic [7:0] want;
          want = (phase_r == PH_R_VER) ? SOCKS_VER :
                 (phase_r == PH_R_CMD) ? CMD_CONNECT : RSV_BYTE;
          if (item_byte != want) begin
            phase_nxt = PH_CLOSED;
            res.cnt   = 2'd1;
            res.r0    = make_res(KIND_ERROR, item_byte, AK_IPV4, 16'd0, 8'd0,
                                 ERR_HEADER, 1'b1);
          end else if (phase_r == PH_R_VER) begin
            phase_nxt = PH_R_CMD;
          end else if (phase_r == PH_R_CMD) begin
            phase_nxt = PH_R_RSV;
          end else begin
            phase_nxt = PH_R_ATYP;
          end
        end
        PH_R_ATYP: begin
          case (item_byte)
            ATYP_IPV4: begin
              akind_nxt      = AK_IPV4;
              alen_nxt       = IPV4_LEN;
              bytes_left_nxt = IPV4_LEN;
              phase_nxt      = PH_ADDR;
            end
            ATYP_IPV6: begin
              akind_nxt      = AK_IPV6;
              alen_nxt       = IPV6_LEN;
              bytes_left_nxt = IPV6_LEN;
              phase_nxt      = PH_ADDR;
            end
            ATYP_DOMAIN: begin
              akind_nxt = AK_DOMAIN;
              phase_nxt = PH_DLEN;
            end
            default: begin
              phase_nxt = PH_CLOSED;
              res.cnt   = 2'd1;
              res.r0    = make_res(KIND_ERROR, item_byte, AK_IPV4, 16'd0, 8'd0,
                                   ERR_ATYP, 1'b1);
            end
          endcase
        end
        PH_DLEN: begin
          if (item_byte == 8'd0 || item_byte > max_dlen_r) begin
            phase_nxt = PH_CLOSED;
            res.cnt   = 2'd1;
            res.r0    = make_res(KIND_ERROR, item_byte, AK_IPV4, 16'd0, 8'd0,
                                 ERR_DLEN, 1'b1);
          end else begin
            alen_nxt       = item_byte;
            bytes_left_nxt = item_byte;
            phase_nxt      = PH_ADDR;
          end
        end
        PH_ADDR: begin
          bytes_left_nxt = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_nxt = PH_PORT_H;
          end
          res.cnt = 2'd1;
          res.r0  = make_res(KIND_ADDR, item_byte, AK_IPV4, 16'd0, 8'd0, ERR_NONE,
                             bl_dec == 8'd0);
        end
        PH_PORT_H: begin
          port_high_nxt = item_byte;
          phase_nxt     = PH_PORT_L;
        end
        PH_PORT_L: begin
          phase_nxt = PH_EST;
          res.cnt   = 2'd1;
          res.r0    = make_res(KIND_CONNECT, 8'd0, akind_r, {port_high_r, item_byte},
                               alen_r, ERR_NONE, 1'b1);
        end
        PH_EST: begin
          res.cnt = 2'd1;
          res.r0  = make_res(KIND_PAYLOAD, item_byte, AK_IPV4, 16'd0, 8'd0, ERR_NONE,
                             item_last);
        end
        default: begin
          // Closed session: drop the byte.
          res.cnt = 2'd0;
        end
      endcase
    end
  end

endmodule

[hdl/s5hp_out_queue.sv]
module s5hp_out_queue #(
  parameter int DEPTH = s5hp_pkg::OUT_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic [1:0]           push_cnt,
  input  s5hp_pkg::result_t    push0,
  input  s5hp_pkg::result_t    push1,
  output logic                 room,
  output logic                 head_valid,
  input  logic                 head_ready,
  output s5hp_pkg::result_t    head
);
  import s5hp_pkg::*;

  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  result_t            slot_r [DEPTH];
  logic [IDX_W-1:0]   rd_ptr_r, wr_ptr_r;
  logic [IDX_W-1:0]   wr_ptr_p1;
  logic [CNT_W-1:0]   count_r;
  logic               pop;

  assign head_valid = (count_r != '0);
  assign pop        = head_valid && head_ready;
  assign head       = slot_r[rd_ptr_r];
  assign wr_ptr_p1  = wr_ptr_r + IDX_W'(1);

  // Space for a full two-result burst, without counting this cycle's pop.
  assign room = (count_r <= CNT_W'(DEPTH - 2));

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_ptr_r <= '0;
      wr_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_r + IDX_W'(push_cnt);
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + IDX_W'(1);
      end
      count_r <= count_r + CNT_W'(push_cnt) - CNT_W'(pop);
    end
  end

  // Result slots.
  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      slot_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      slot_r[wr_ptr_p1] <= push1;
    end
  end

endmodule

[hdl/s5hp_checker.sv]
module s5hp_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import s5hp_pkg::*;

  // Reset empties the result stream.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result pending after reset");

  // A stalled result stays offered.
  a_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("result withdrawn while stalled");

  // Error results close a run and carry a nonzero code.
  a_error_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_ERROR |-> out_tlast && out_tdata[36:34] != ERR_NONE)
    else $error("malformed error result");

  // The closing reply byte is the no-authentication method.
  a_reply_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == KIND_REPLY && out_tlast |-> out_tdata[7:0] == METHOD_NONE)
    else $error("bad method reply byte");

endmodule

bind socks5_handshake_parser_unit s5hp_checker u_s5hp_checker (.*);
